@@ src/fwdv_pkg.sv @@
// Package for the FIFO with delete-by-value block.
// Holds the queue depth, command and status codes, and the item struct types.
// No dependencies.
package fwdv_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] result_value;
    logic [CNT_W-1:0]         occupancy;
  } out_item_t;

  // Command broadcast from the top level to every cell.
  typedef struct packed {
    logic                     go;
    func_t                    op;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

@@ src/fifo_with_delete_by_value.sv @@
// Top level of the FIFO with delete-by-value block.
// Builds the chain of fwdv_cell storage cells and the registered result stage.
// Depends on fwdv_pkg and fwdv_cell.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one command item:
//   push a value at the tail, pop the head, or delete the first entry from
//   the head that equals the value. Every command yields exactly one result
//   item on the output channel (out_valid/out_ready/out_data) with a status,
//   the popped or deleted value (zero unless status is ok) and the number of
//   entries held after the command.
//   Result: it is registered and appears in the cycle after the command is accepted.
//   Throughput: one command per cycle while out_ready stays high. All cells compare against the value
//   in parallel and a one-bit "match seen" signal ripples down the chain, so
//   the whole command finishes in the cycle it is accepted.
//   Reset (rst_n low, synchronous) clears all cell valid bits, the count
//   and the result valid bit; entry data and the result payload are left as they were.
//   Receiver stall: the result is held in the output register; a new
//   command is taken in the same cycle the held result is taken, else the
//   input channel waits.
module fifo_with_delete_by_value (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fwdv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fwdv_pkg::out_item_t out_data
);

  localparam int D = fwdv_pkg::DEPTH;

  fwdv_pkg::cell_ctl_t               ctl;
  logic                              accept;
  logic [D-1:0]                      cell_valid;
  logic signed [fwdv_pkg::DATA_W-1:0] cell_data [D];
  logic [D:0]                        seen;
  // Neighbor views for each cell: valid bit on the left, valid and data on the right.
  logic [D-1:0]                      lvalid;
  logic [D-1:0]                      rvalid;
  logic signed [fwdv_pkg::DATA_W-1:0] rdata [D];

  logic [fwdv_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       out_valid_r, out_valid_nxt;
  fwdv_pkg::out_item_t        out_data_r, out_data_nxt;
  logic                       full;
  logic                       empty;

  // Take a new command whenever the result stage is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctl = '{go: accept, op: fwdv_pkg::func_t'(in_data.func), value: in_data.value};

  assign full  = (count_r == fwdv_pkg::CNT_W'(D));
  assign empty = (count_r == '0);

  // Chain boundaries: the head sees no earlier match and a valid left side;
  // the tail shifts in an invalid entry.
  assign seen[0]     = 1'b0;
  assign lvalid[0]   = 1'b1;
  assign rvalid[D-1] = 1'b0;
  assign rdata[D-1]  = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    fwdv_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_valid  (lvalid[i]),
      .right_valid (rvalid[i]),
      .right_data  (rdata[i]),
      .seen_in     (seen[i]),
      .seen_out    (seen[i+1]),
      .valid_o     (cell_valid[i]),
      .data_o      (cell_data[i])
    );
    if (i > 0) begin : g_left
      assign lvalid[i] = cell_valid[i-1];
    end
    if (i < D - 1) begin : g_right
      assign rvalid[i] = cell_valid[i+1];
      assign rdata[i]  = cell_data[i+1];
    end
  end

  // Work out the result and the new count for the accepted command.
  always_comb begin
    count_nxt    = count_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = fwdv_pkg::ST_OK;
      out_data_nxt.result_value = '0;
      case (ctl.op)
        fwdv_pkg::FUNC_PUSH: begin
          if (full) begin
            out_data_nxt.status = fwdv_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + fwdv_pkg::CNT_W'(1);
          end
        end
        fwdv_pkg::FUNC_POP: begin
          if (empty) begin
            out_data_nxt.status = fwdv_pkg::ST_EMPTY;
          end else begin
            out_data_nxt.result_value = cell_data[0];
            count_nxt = count_r - fwdv_pkg::CNT_W'(1);
          end
        end
        fwdv_pkg::FUNC_DEL: begin
          // A match equals the searched value, so report that value.
          if (seen[D]) begin
            out_data_nxt.result_value = ctl.value;
            count_nxt = count_r - fwdv_pkg::CNT_W'(1);
          end else begin
            out_data_nxt.status = fwdv_pkg::ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
      out_data_nxt.occupancy = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result payload until it is taken.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/fwdv_cell.sv @@
// One storage cell of the FIFO chain: an entry and its valid bit.
// Shifts from its right neighbor on pop or on delete at or after the first match.
// Depends on fwdv_pkg.
module fwdv_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fwdv_pkg::cell_ctl_t               ctl,
  input  logic                              left_valid,
  input  logic                              right_valid,
  input  logic signed [fwdv_pkg::DATA_W-1:0] right_data,
  input  logic                              seen_in,
  output logic                              seen_out,
  output logic                              valid_o,
  output logic signed [fwdv_pkg::DATA_W-1:0] data_o
);

  logic                               valid_r, valid_nxt;
  logic signed [fwdv_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                               match;
  logic                               shift;
  logic                               load;

  assign match    = valid_r && (data_r == ctl.value);
  assign seen_out = seen_in | match;

  always_comb begin
    shift = 1'b0;
    load  = 1'b0;
    if (ctl.go) begin
      case (ctl.op)
        fwdv_pkg::FUNC_POP:  shift = 1'b1;
        fwdv_pkg::FUNC_DEL:  shift = seen_out;
        fwdv_pkg::FUNC_PUSH: load  = !valid_r && left_valid;
        default:             ;
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (shift) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

@@ tb/sv/fifo_with_delete_by_value_tb.sv @@
`timescale 1ns / 100ps
// Testbench for fifo_with_delete_by_value: a queue predictor in a small
// scoreboard class plus plain driver tasks for the command and result channels.
// Depends on fwdv_pkg and the fifo_with_delete_by_value RTL.

// Tracks the queue contents and the result each accepted command must produce.
class fifo_scoreboard;
  logic signed [fwdv_pkg::DATA_W-1:0] held[$];
  fwdv_pkg::out_item_t awaited[$];
  int errors = 0;

  function void report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endfunction

  // Apply one accepted command to the shadow queue and queue its result.
  function void note_command(fwdv_pkg::in_item_t cmd);
    fwdv_pkg::out_item_t want;
    int k;
    bit hit;
    want.status = fwdv_pkg::ST_OK;
    want.result_value = '0;
    hit = 1'b0;
    case (cmd.func)
      fwdv_pkg::FUNC_PUSH: begin
        if (held.size() >= fwdv_pkg::DEPTH) want.status = fwdv_pkg::ST_FULL;
        else held.push_back(cmd.value);
      end
      fwdv_pkg::FUNC_POP: begin
        if (held.size() == 0) want.status = fwdv_pkg::ST_EMPTY;
        else want.result_value = held.pop_front();
      end
      fwdv_pkg::FUNC_DEL: begin
        want.status = fwdv_pkg::ST_NOT_FOUND;
        for (k = 0; k < held.size() && !hit; k++) begin
          if (held[k] === cmd.value) begin
            want.result_value = held[k];
            want.status = fwdv_pkg::ST_OK;
            held.delete(k);
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    want.occupancy = fwdv_pkg::CNT_W'(held.size());
    awaited.push_back(want);
  endfunction

  // Compare one accepted result with the oldest outstanding expectation.
  function void check_result(fwdv_pkg::out_item_t got);
    fwdv_pkg::out_item_t want;
    if (awaited.size() == 0) begin
      report($sformatf("result with nothing outstanding: status %0d value %0d occ %0d",
                       got.status, got.result_value, got.occupancy));
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.result_value !== want.result_value)
      report($sformatf("result_value got %0d want %0d", got.result_value,
                       want.result_value));
    if (got.occupancy !== want.occupancy)
      report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
  endfunction
endclass

module fifo_with_delete_by_value_tb;

  localparam int RANDOM_ITEMS   = 1600;
  localparam int WATCHDOG_LIMIT = 500;   // cycles with no handshake on either side
  localparam int TAIL_CYCLES    = 4;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  fwdv_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  fwdv_pkg::out_item_t out_data;

  fifo_scoreboard sb = new();

  int quiet_cycles = 0;
  int send_run = 0;   // remaining back-to-back items on the command side
  int take_run = 0;   // remaining back-to-back items on the result side

  fifo_with_delete_by_value uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draw a random wait; now and then start a run of zero waits so
  // stretches of full-rate traffic appear on each side.
  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic fwdv_pkg::in_item_t make_cmd(fwdv_pkg::func_t f,
                                                  logic signed [fwdv_pkg::DATA_W-1:0] v);
    fwdv_pkg::in_item_t c;
    c.func = f;
    c.value = v;
    return c;
  endfunction

  // Pick a random command. push_pct steers the fill level so the queue
  // swings between empty and full; values favor a small range and copies of
  // held entries so deletes often find a match (and duplicates).
  function automatic fwdv_pkg::in_item_t pick_command(int push_pct);
    fwdv_pkg::in_item_t c;
    int roll;
    int n;
    int small_val;
    n = sb.held.size();
    roll = $urandom_range(0, 99);
    if (roll < 3) c.func = fwdv_pkg::FUNC_NOP;
    else if ($urandom_range(0, 99) < push_pct) c.func = fwdv_pkg::FUNC_PUSH;
    else if ($urandom_range(0, 1) == 1) c.func = fwdv_pkg::FUNC_POP;
    else c.func = fwdv_pkg::FUNC_DEL;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      small_val = $urandom_range(0, 8);
      c.value = small_val - 3;
    end else if (roll < 60 && n > 0) begin
      c.value = sb.held[$urandom_range(0, n - 1)];
    end else if (roll < 70) begin
      case ($urandom_range(0, 3))
        0:       c.value = 32'sh7FFF_FFFF;
        1:       c.value = 32'sh8000_0000;
        2:       c.value = '0;
        default: c.value = -1;
      endcase
    end else begin
      c.value = $urandom;
    end
    return c;
  endfunction

  // Present one command after a random gap and hold it until accepted.
  // Drop valid only when a gap follows, so valid never toggles within a step.
  task automatic send_command(fwdv_pkg::in_item_t cmd);
    int gap;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the command side until every outstanding result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  // Result side: stall a random number of cycles per item, then take it.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = draw_wait(take_run);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Monitor both channels at each edge: check results first, then note the
  // accepted command; also advance the watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_command(in_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus: reset, a directed pass over the corner cases, then random traffic.
  initial begin
    int k;
    int sent;
    int push_pct;
    fwdv_pkg::in_item_t cmd;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue: pop, delete, and an unused selector.
    send_command(make_cmd(fwdv_pkg::FUNC_POP, 32'sd0));
    send_command(make_cmd(fwdv_pkg::FUNC_DEL, 32'sd5));
    send_command(make_cmd(fwdv_pkg::FUNC_NOP, -1));
    // Fill to capacity with extremes, minus one and duplicates.
    send_command(make_cmd(fwdv_pkg::FUNC_PUSH, 32'sh7FFF_FFFF));
    send_command(make_cmd(fwdv_pkg::FUNC_PUSH, 32'sh8000_0000));
    send_command(make_cmd(fwdv_pkg::FUNC_PUSH, -1));
    send_command(make_cmd(fwdv_pkg::FUNC_PUSH, 32'sd0));
    for (k = 0; k < fwdv_pkg::DEPTH - 4; k++)
      send_command(make_cmd(fwdv_pkg::FUNC_PUSH, (k % 3 == 0) ? 32'sd7 : 32'(k + 10)));
    // Full queue: dropped push.
    send_command(make_cmd(fwdv_pkg::FUNC_PUSH, 32'sd99));
    // Delete a minus-one entry from the middle, then the first of duplicates.
    send_command(make_cmd(fwdv_pkg::FUNC_DEL, -1));
    send_command(make_cmd(fwdv_pkg::FUNC_DEL, 32'sd7));
    send_command(make_cmd(fwdv_pkg::FUNC_DEL, 32'sd12345));
    send_command(make_cmd(fwdv_pkg::FUNC_POP, 32'sd0));
    send_command(make_cmd(fwdv_pkg::FUNC_NOP, 32'sh8000_0000));
    send_command(make_cmd(fwdv_pkg::FUNC_POP, 32'sd0));

    // Pause until the queue has answered everything, then go random.
    drain_results();

    sent = 0;
    push_pct = 50;
    while (sent < RANDOM_ITEMS) begin
      // Re-steer the fill level every few dozen items.
      if (sent % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      cmd = pick_command(push_pct);
      send_command(cmd);
      if (cmd.func != fwdv_pkg::FUNC_NOP) sent++;
      if (sent == RANDOM_ITEMS / 2 && cmd.func != fwdv_pkg::FUNC_NOP) drain_results();
    end

    // Wait out every outstanding result, then a short tail for strays.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
